>>> hw/rtl/mid_pkg.sv
// Shared types, codes and length functions for the MOV instruction decoder.
`default_nettype none
package mid_pkg;

  localparam logic [2:0] FORM_RM_REG     = 3'd0;
  localparam logic [2:0] FORM_IMM_TO_RM  = 3'd1;
  localparam logic [2:0] FORM_IMM_TO_REG = 3'd2;
  localparam logic [2:0] FORM_MEM_TO_ACC = 3'd3;
  localparam logic [2:0] FORM_ACC_TO_MEM = 3'd4;
  localparam logic [2:0] FORM_NOT_MOV    = 3'd5;

  localparam logic [1:0] MOD_MEM      = 2'd0;
  localparam logic [1:0] MOD_DISP8    = 2'd1;
  localparam logic [1:0] MOD_DISP16   = 2'd2;
  localparam logic [1:0] MOD_REGISTER = 2'd3;
  localparam logic [2:0] RM_DIRECT    = 3'b110;
  localparam logic [15:0] EXTEND8     = 16'hFF00;

  // Raw bytes of one complete instruction, as collected by the front end.
  typedef struct packed {
    logic [7:0]  opcode;
    logic [7:0]  modrm;
    logic [15:0] disp;
    logic [15:0] data;
  } mid_rec_t;

  function automatic logic [2:0] form_of(input logic [7:0] op);
    logic [2:0] f;
    begin
      if ((op & 8'hFC) == 8'h88) f = FORM_RM_REG;
      else if ((op & 8'hFE) == 8'hC6) f = FORM_IMM_TO_RM;
      else if ((op & 8'hF0) == 8'hB0) f = FORM_IMM_TO_REG;
      else if ((op & 8'hFE) == 8'hA0) f = FORM_MEM_TO_ACC;
      else if ((op & 8'hFE) == 8'hA2) f = FORM_ACC_TO_MEM;
      else f = FORM_NOT_MOV;
      return f;
    end
  endfunction

  function automatic logic [1:0] disp_len(input logic [2:0] f, input logic [7:0] modrm);
    logic [1:0] n;
    begin
      n = 2'd0;
      if (f == FORM_MEM_TO_ACC || f == FORM_ACC_TO_MEM) begin
        n = 2'd2;
      end else if (f == FORM_RM_REG || f == FORM_IMM_TO_RM) begin
        if (modrm[7:6] == MOD_DISP8) n = 2'd1;
        else if (modrm[7:6] == MOD_DISP16) n = 2'd2;
        else if (modrm[7:6] == MOD_MEM && modrm[2:0] == RM_DIRECT) n = 2'd2;
      end
      return n;
    end
  endfunction

  function automatic logic [1:0] data_len(input logic [2:0] f, input logic [7:0] op);
    logic [1:0] n;
    begin
      n = 2'd0;
      if (f == FORM_IMM_TO_RM) n = {1'b0, 1'b1} + {1'b0, op[0]};
      else if (f == FORM_IMM_TO_REG) n = {1'b0, 1'b1} + {1'b0, op[3]};
      return n;
    end
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/mid_front.sv
// Front end: collects code bytes and hands each complete instruction on.
`default_nettype none
module mid_front
  import mid_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       accept,
  input  wire logic [7:0] code_byte,
  output mid_rec_t        rec,
  output logic            push
);

  logic [2:0]  idx_r, idx_nxt;
  logic [2:0]  len_r, len_nxt;
  logic [7:0]  op_r, op_nxt;
  logic [7:0]  modrm_r, modrm_nxt;
  logic [15:0] disp_r, disp_nxt;
  logic [15:0] data_r, data_nxt;
  logic        done;
  logic [2:0]  f;
  logic [2:0]  hdr, dl3, ql3, dend, qend;

  always_comb begin
    op_nxt    = op_r;
    modrm_nxt = modrm_r;
    disp_nxt  = disp_r;
    data_nxt  = data_r;
    idx_nxt   = idx_r;
    len_nxt   = len_r;
    done      = 1'b0;
    f         = form_of(op_r);
    hdr       = 3'd1;
    dl3       = 3'd0;
    ql3       = 3'd0;
    dend      = 3'd0;
    qend      = 3'd0;
    if (idx_r == 3'd0) begin
      op_nxt    = code_byte;
      modrm_nxt = 8'd0;
      disp_nxt  = 16'd0;
      data_nxt  = 16'd0;
      f         = form_of(code_byte);
      if (f == FORM_NOT_MOV) begin
        done = 1'b1;
      end else begin
        idx_nxt = 3'd1;
        if (f == FORM_RM_REG || f == FORM_IMM_TO_RM) begin
          len_nxt = 3'd0;
        end else begin
          len_nxt = 3'd1 + {1'b0, disp_len(f, 8'd0)} + {1'b0, data_len(f, code_byte)};
        end
      end
    end else if ((f == FORM_RM_REG || f == FORM_IMM_TO_RM) && idx_r == 3'd1) begin
      modrm_nxt = code_byte;
      len_nxt   = 3'd2 + {1'b0, disp_len(f, code_byte)} + {1'b0, data_len(f, op_r)};
      idx_nxt   = 3'd2;
      done      = (len_nxt <= 3'd2);
    end else begin
      hdr  = (f == FORM_RM_REG || f == FORM_IMM_TO_RM) ? 3'd2 : 3'd1;
      dl3  = {1'b0, disp_len(f, modrm_r)};
      ql3  = {1'b0, data_len(f, op_r)};
      dend = hdr + dl3;
      qend = dend + ql3;
      if (idx_r >= hdr && idx_r < dend) begin
        if (idx_r == hdr) disp_nxt = {disp_r[15:8], code_byte};
        else disp_nxt = {code_byte, disp_r[7:0]};
      end else if (idx_r >= dend && idx_r < qend) begin
        if (idx_r == dend) data_nxt = {data_r[15:8], code_byte};
        else data_nxt = {code_byte, data_r[7:0]};
      end
      idx_nxt = idx_r + 3'd1;
      done    = (idx_nxt == 3'd0) || (idx_nxt >= len_r);
    end
    if (done) begin
      idx_nxt = 3'd0;
      len_nxt = 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 3'd0;
      len_r   <= 3'd0;
      op_r    <= 8'd0;
      modrm_r <= 8'd0;
      disp_r  <= 16'd0;
      data_r  <= 16'd0;
    end else if (accept) begin
      idx_r   <= idx_nxt;
      len_r   <= len_nxt;
      op_r    <= op_nxt;
      modrm_r <= modrm_nxt;
      disp_r  <= disp_nxt;
      data_r  <= data_nxt;
    end
  end

  assign push         = accept && done;
  assign rec.opcode   = op_nxt;
  assign rec.modrm    = modrm_nxt;
  assign rec.disp     = disp_nxt;
  assign rec.data     = data_nxt;

endmodule
`default_nettype wire

>>> hw/rtl/mid_queue.sv
// Small instruction queue between the front end and the back end.
`default_nettype none
module mid_queue
  import mid_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire mid_rec_t push_rec,
  output logic          full,
  input  wire logic     pop,
  output logic          not_empty,
  output mid_rec_t      head_rec
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  mid_rec_t        mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r, count_nxt;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + CW'(1);
    else if (pop && !push) count_nxt = count_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) wr_ptr_r <= (wr_ptr_r == LAST) ? '0 : wr_ptr_r + PW'(1);
      if (pop) rd_ptr_r <= (rd_ptr_r == LAST) ? '0 : rd_ptr_r + PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_rec;
  end

  assign full      = (count_r == FULL_COUNT);
  assign not_empty = (count_r != '0);
  assign head_rec  = mem_r[rd_ptr_r];

`ifndef ASSERT_OFF
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("request pushed into a full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n) pop |-> not_empty)
    else $error("request popped from an empty queue");
  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> count_r == $past(count_r) + CW'(1))
    else $error("queue count did not follow a push");
`endif

endmodule
`default_nettype wire

>>> hw/rtl/mid_back.sv
// Back end: turns the raw instruction bytes into the decoded record.
`default_nettype none
module mid_back
  import mid_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         q_not_empty,
  input  wire mid_rec_t     q_rec,
  output logic              pop,
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic [2:0]        out_form,
  output logic              out_to_register,
  output logic              out_is_word,
  output logic [1:0]        out_mode,
  output logic [2:0]        out_reg_field,
  output logic [2:0]        out_rm_field,
  output logic              out_direct_address,
  output logic signed [15:0] out_displacement,
  output logic [15:0]       out_address,
  output logic [15:0]       out_immediate
);

  logic        valid_r;
  logic [2:0]  form_r, form_nxt;
  logic        d_r, d_nxt, w_r, w_nxt, dir_r, dir_nxt;
  logic [1:0]  mode_r, mode_nxt;
  logic [2:0]  reg_r, reg_nxt, rm_r, rm_nxt;
  logic [15:0] disp_r, disp_nxt, addr_r, addr_nxt, imm_r, imm_nxt;
  logic [1:0]  md;

  always_comb begin
    form_nxt = form_of(q_rec.opcode);
    md       = q_rec.modrm[7:6];
    d_nxt    = 1'b0;
    w_nxt    = 1'b0;
    mode_nxt = MOD_MEM;
    reg_nxt  = 3'd0;
    rm_nxt   = 3'd0;
    dir_nxt  = 1'b0;
    disp_nxt = 16'd0;
    addr_nxt = 16'd0;
    imm_nxt  = 16'd0;
    case (form_nxt)
      FORM_RM_REG, FORM_IMM_TO_RM: begin
        d_nxt    = (form_nxt == FORM_RM_REG) ? q_rec.opcode[1] : 1'b0;
        w_nxt    = q_rec.opcode[0];
        mode_nxt = md;
        reg_nxt  = q_rec.modrm[5:3];
        rm_nxt   = q_rec.modrm[2:0];
        dir_nxt  = (md == MOD_MEM) && (q_rec.modrm[2:0] == RM_DIRECT);
        if (md == MOD_DISP8) begin
          disp_nxt = q_rec.disp[7] ? (EXTEND8 | {8'd0, q_rec.disp[7:0]})
                                   : {8'd0, q_rec.disp[7:0]};
        end else if (md == MOD_DISP16) begin
          disp_nxt = q_rec.disp;
        end
        if (dir_nxt) addr_nxt = q_rec.disp;
        if (form_nxt == FORM_IMM_TO_RM) imm_nxt = q_rec.data;
      end
      FORM_IMM_TO_REG: begin
        d_nxt    = 1'b1;
        w_nxt    = q_rec.opcode[3];
        mode_nxt = MOD_REGISTER;
        reg_nxt  = q_rec.opcode[2:0];
        imm_nxt  = q_rec.data;
      end
      FORM_MEM_TO_ACC, FORM_ACC_TO_MEM: begin
        d_nxt    = (form_nxt == FORM_MEM_TO_ACC);
        w_nxt    = q_rec.opcode[0];
        dir_nxt  = 1'b1;
        addr_nxt = q_rec.disp;
      end
      default: begin
        form_nxt = FORM_NOT_MOV;
      end
    endcase
  end

  assign pop = q_not_empty && (!valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!valid_r || !out_stall) begin
      valid_r <= q_not_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      form_r <= form_nxt;
      d_r    <= d_nxt;
      w_r    <= w_nxt;
      mode_r <= mode_nxt;
      reg_r  <= reg_nxt;
      rm_r   <= rm_nxt;
      dir_r  <= dir_nxt;
      disp_r <= disp_nxt;
      addr_r <= addr_nxt;
      imm_r  <= imm_nxt;
    end
  end

  assign out_valid          = valid_r;
  assign out_form           = form_r;
  assign out_to_register    = d_r;
  assign out_is_word        = w_r;
  assign out_mode           = mode_r;
  assign out_reg_field      = reg_r;
  assign out_rm_field       = rm_r;
  assign out_direct_address = dir_r;
  assign out_displacement   = disp_r;
  assign out_address        = addr_r;
  assign out_immediate      = imm_r;

endmodule
`default_nettype wire

>>> hw/rtl/mov_instruction_decoder_unit.sv
// Top level: 8086 MOV decoder, one code byte per request, one record per instruction.
// Throughput: one code byte per cycle, sustained, as long as the output is not stalled.
// The edge that accepts the last byte of an instruction writes its record into the queue;
// the back end then loads it into the output register when it pops the queue.
// Input stalls only when the instruction queue is full, set by its depth.
// Reset (rst_n low, synchronous) empties the queue and output and restarts at a first byte.
`default_nettype none
module mov_instruction_decoder_unit
  import mid_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [7:0]    in_code_byte,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [2:0]         out_form,
  output logic               out_to_register,
  output logic               out_is_word,
  output logic [1:0]         out_mode,
  output logic [2:0]         out_reg_field,
  output logic [2:0]         out_rm_field,
  output logic               out_direct_address,
  output logic signed [15:0] out_displacement,
  output logic [15:0]        out_address,
  output logic [15:0]        out_immediate
);

  mid_rec_t front_rec, head_rec;
  logic     push, full, pop, not_empty, accept;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  mid_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .code_byte (in_code_byte),
    .rec       (front_rec),
    .push      (push)
  );

  mid_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_rec  (front_rec),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .head_rec  (head_rec)
  );

  mid_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_not_empty        (not_empty),
    .q_rec              (head_rec),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_form           (out_form),
    .out_to_register    (out_to_register),
    .out_is_word        (out_is_word),
    .out_mode           (out_mode),
    .out_reg_field      (out_reg_field),
    .out_rm_field       (out_rm_field),
    .out_direct_address (out_direct_address),
    .out_displacement   (out_displacement),
    .out_address        (out_address),
    .out_immediate      (out_immediate)
  );

endmodule
`default_nettype wire

>>> dv/tb_mov_instruction_decoder_unit.sv
// Self-checking testbench for the 8086 MOV decoder: directed table, random code streams, scoreboard.
module tb_mov_instruction_decoder_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import mid_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_BYTES = 900;
  localparam int TAIL_CYCLES  = 16;

  typedef struct packed {
    logic [2:0]  form;
    logic        to_reg;
    logic        word;
    logic [1:0]  mode;
    logic [2:0]  reg_no;
    logic [2:0]  rm_no;
    logic        direct;
    logic [15:0] disp;
    logic [15:0] addr;
    logic [15:0] imm;
  } mov_rec_t;

  typedef struct packed {
    logic [7:0] code;
    logic       typed;
    mov_rec_t   want;
  } stim_t;

  localparam mov_rec_t BLANK = '0;
  localparam mov_rec_t NOT_MOV_REC = {FORM_NOT_MOV, 1'b0, 1'b0, MOD_MEM, 3'd0, 3'd0, 1'b0,
                                      16'h0000, 16'h0000, 16'h0000};
  localparam mov_rec_t AX_FFFF_REC = {FORM_IMM_TO_REG, 1'b1, 1'b1, MOD_REGISTER, 3'd0, 3'd0,
                                      1'b0, 16'h0000, 16'h0000, 16'hFFFF};
  localparam mov_rec_t LOAD_AX_REC = {FORM_MEM_TO_ACC, 1'b1, 1'b1, MOD_MEM, 3'd0, 3'd0, 1'b1,
                                      16'h0000, 16'h1234, 16'h0000};
  localparam mov_rec_t STORE_AL_REC = {FORM_ACC_TO_MEM, 1'b0, 1'b0, MOD_MEM, 3'd0, 3'd0, 1'b1,
                                       16'h0000, 16'h0000, 16'h0000};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_code_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_form;
  logic        out_to_register;
  logic        out_is_word;
  logic [1:0]  out_mode;
  logic [2:0]  out_reg_field;
  logic [2:0]  out_rm_field;
  logic        out_direct_address;
  logic signed [15:0] out_displacement;
  logic [15:0] out_address;
  logic [15:0] out_immediate;

  // Directed instructions; typed rows carry a hand-written record on their last byte.
  stim_t dir_tab [0:27] = '{
    {8'h00, 1'b1, NOT_MOV_REC}, {8'hFF, 1'b1, NOT_MOV_REC}, {8'h8E, 1'b1, NOT_MOV_REC},
    {8'h8B, 1'b0, BLANK}, {8'h46, 1'b0, BLANK}, {8'h80, 1'b0, BLANK},
    {8'h89, 1'b0, BLANK}, {8'h96, 1'b0, BLANK}, {8'hFF, 1'b0, BLANK}, {8'h7F, 1'b0, BLANK},
    {8'hC7, 1'b0, BLANK}, {8'h06, 1'b0, BLANK}, {8'h00, 1'b0, BLANK}, {8'h80, 1'b0, BLANK},
    {8'hFF, 1'b0, BLANK}, {8'hFF, 1'b0, BLANK},
    {8'hC6, 1'b0, BLANK}, {8'hFF, 1'b0, BLANK}, {8'h5A, 1'b0, BLANK},
    {8'hB8, 1'b0, BLANK}, {8'hFF, 1'b0, BLANK}, {8'hFF, 1'b1, AX_FFFF_REC},
    {8'hA1, 1'b0, BLANK}, {8'h34, 1'b0, BLANK}, {8'h12, 1'b1, LOAD_AX_REC},
    {8'hA2, 1'b0, BLANK}, {8'h00, 1'b0, BLANK}, {8'h00, 1'b1, STORE_AL_REC}
  };

  stim_t    stim_q [$];
  mov_rec_t exp_q [$];

  // Decoder state as the predictor tracks it.
  logic [2:0]  pr_pos = 3'd0;
  logic [7:0]  pr_op = 8'h00;
  logic [7:0]  pr_modrm = 8'h00;
  logic [15:0] pr_disp = 16'h0000;
  logic [15:0] pr_data = 16'h0000;
  logic [2:0]  pr_len = 3'd0;

  int cycle_cnt = 0;
  int err_cnt = 0;
  int rec_cnt = 0;
  int sent_cnt = 0;
  int form_seen [0:5] = '{0, 0, 0, 0, 0, 0};
  logic [9:0] stall_ctr = 10'd0;

  mov_instruction_decoder_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_code_byte       (in_code_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_form           (out_form),
    .out_to_register    (out_to_register),
    .out_is_word        (out_is_word),
    .out_mode           (out_mode),
    .out_reg_field      (out_reg_field),
    .out_rm_field       (out_rm_field),
    .out_direct_address (out_direct_address),
    .out_displacement   (out_displacement),
    .out_address        (out_address),
    .out_immediate      (out_immediate)
  );

  always #5 clk = ~clk;

  function automatic logic [2:0] op_form(input logic [7:0] op);
    casez (op)
      8'b1000_10??: return FORM_RM_REG;
      8'b1100_011?: return FORM_IMM_TO_RM;
      8'b1011_????: return FORM_IMM_TO_REG;
      8'b1010_000?: return FORM_MEM_TO_ACC;
      8'b1010_001?: return FORM_ACC_TO_MEM;
      default:      return FORM_NOT_MOV;
    endcase
  endfunction

  // Displacement or direct-address bytes that follow the header.
  function automatic int disp_count(input logic [2:0] f, input logic [7:0] m);
    if (f == FORM_MEM_TO_ACC || f == FORM_ACC_TO_MEM) return 2;
    if (f > FORM_IMM_TO_RM) return 0;
    case (m[7:6])
      MOD_DISP8:  return 1;
      MOD_DISP16: return 2;
      MOD_MEM:    return (m[2:0] == RM_DIRECT) ? 2 : 0;
      default:    return 0;
    endcase
  endfunction

  function automatic int imm_count(input logic [2:0] f, input logic [7:0] op);
    if (f == FORM_IMM_TO_RM) return 1 + int'(op[0]);
    if (f == FORM_IMM_TO_REG) return 1 + int'(op[3]);
    return 0;
  endfunction

  function automatic mov_rec_t close_instr();
    mov_rec_t   r;
    logic [2:0] f;
    logic [1:0] md;
    r = '0;
    f = op_form(pr_op);
    md = pr_modrm[7:6];
    r.form = f;
    if (f <= FORM_IMM_TO_RM) begin
      r.to_reg = (f == FORM_RM_REG) ? pr_op[1] : 1'b0;
      r.word = pr_op[0];
      r.mode = md;
      r.reg_no = pr_modrm[5:3];
      r.rm_no = pr_modrm[2:0];
      r.direct = (md == MOD_MEM && pr_modrm[2:0] == RM_DIRECT);
      if (md == MOD_DISP8) r.disp = {{8{pr_disp[7]}}, pr_disp[7:0]};
      else if (md == MOD_DISP16) r.disp = pr_disp;
      if (r.direct) r.addr = pr_disp;
      if (f == FORM_IMM_TO_RM) r.imm = pr_data;
    end else if (f == FORM_IMM_TO_REG) begin
      r.to_reg = 1'b1;
      r.word = pr_op[3];
      r.mode = MOD_REGISTER;
      r.reg_no = pr_op[2:0];
      r.imm = pr_data;
    end else if (f == FORM_MEM_TO_ACC || f == FORM_ACC_TO_MEM) begin
      r.to_reg = (f == FORM_MEM_TO_ACC);
      r.word = pr_op[0];
      r.direct = 1'b1;
      r.addr = pr_disp;
    end
    pr_pos = 3'd0;
    pr_len = 3'd0;
    return r;
  endfunction

  // Advances the predictor by one code byte; returns 1 when an instruction completes.
  function automatic bit decode_byte(input logic [7:0] b, output mov_rec_t r);
    logic [2:0] f;
    int         hdr;
    int         dn;
    int         qn;
    int         k;
    r = '0;
    if (pr_pos == 3'd0) begin
      pr_op = b;
      pr_modrm = 8'h00;
      pr_disp = 16'h0000;
      pr_data = 16'h0000;
      f = op_form(b);
      if (f == FORM_NOT_MOV) begin
        r = close_instr();
        return 1'b1;
      end
      pr_pos = 3'd1;
      pr_len = (f <= FORM_IMM_TO_RM) ? 3'd0
                                     : 3'(1 + disp_count(f, 8'h00) + imm_count(f, b));
      return 1'b0;
    end
    f = op_form(pr_op);
    if (f <= FORM_IMM_TO_RM && pr_pos == 3'd1) begin
      pr_modrm = b;
      pr_len = 3'(2 + disp_count(f, b) + imm_count(f, pr_op));
      pr_pos = 3'd2;
      if (pr_pos >= pr_len) begin
        r = close_instr();
        return 1'b1;
      end
      return 1'b0;
    end
    hdr = (f <= FORM_IMM_TO_RM) ? 2 : 1;
    dn = disp_count(f, pr_modrm);
    qn = imm_count(f, pr_op);
    k = int'(pr_pos);
    if (k >= hdr && k < hdr + dn) begin
      if (k == hdr) pr_disp[7:0] = b;
      else pr_disp[15:8] = b;
    end else if (k >= hdr + dn && k < hdr + dn + qn) begin
      if (k == hdr + dn) pr_data[7:0] = b;
      else pr_data[15:8] = b;
    end
    pr_pos = pr_pos + 3'd1;
    if (pr_pos == 3'd0 || pr_pos >= pr_len) begin
      r = close_instr();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic string rec_text(input mov_rec_t r);
    return $sformatf("form %0d d %0b w %0b mod %0d reg %0d rm %0d dir %0b disp %h addr %h imm %h",
                     r.form, r.to_reg, r.word, r.mode, r.reg_no, r.rm_no, r.direct,
                     r.disp, r.addr, r.imm);
  endfunction

  function automatic void add_byte(input logic [7:0] c);
    stim_q.push_back({c, 1'b0, BLANK});
  endfunction

  // The receiver cycles through calm, light, heavy and periodic stall phases.
  always @(posedge clk) begin
    stall_ctr <= stall_ctr + 10'd1;
    case (stall_ctr[9:8])
      2'd0:    out_stall <= 1'b0;
      2'd1:    out_stall <= ($urandom_range(0, 3) == 0);
      2'd2:    out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= stall_ctr[2];
    endcase
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d records outstanding", cycle_cnt, exp_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin : check_out
    mov_rec_t got;
    mov_rec_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_form, out_to_register, out_is_word, out_mode, out_reg_field, out_rm_field,
             out_direct_address, out_displacement, out_address, out_immediate};
      rec_cnt++;
      if (got.form <= FORM_NOT_MOV) form_seen[got.form]++;
      if (exp_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("%0t: record with nothing expected: %s", $realtime,
                                    rec_text(got));
      end else begin
        want = exp_q.pop_front();
        if (got !== want) begin
          err_cnt++;
          if (err_cnt <= 10) begin
            $display("%0t: mismatch, expected %s", $realtime, rec_text(want));
            $display("%0t:           actual   %s", $realtime, rec_text(got));
          end
        end
      end
    end
  end

  initial begin
    mov_rec_t   pred;
    logic [7:0] op;
    logic [7:0] m;
    logic [2:0] f;
    int         kind;
    int         n_directed;
    int         drain_at;
    int         burst_left;

    foreach (dir_tab[i]) stim_q.push_back(dir_tab[i]);
    n_directed = stim_q.size();
    drain_at = 0;

    // Mostly whole instructions with random content, plus stray bytes.
    while (stim_q.size() < n_directed + RANDOM_BYTES) begin
      if (drain_at == 0 && stim_q.size() >= n_directed + RANDOM_BYTES / 2)
        drain_at = stim_q.size();
      kind = $urandom_range(0, 9);
      m = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 3) == 0) m[2:0] = RM_DIRECT;
      case (kind)
        0, 1, 2: op = 8'h88 | 8'($urandom_range(0, 3));
        3, 4:    op = 8'hC6 | 8'($urandom_range(0, 1));
        5, 6:    op = 8'hB0 | 8'($urandom_range(0, 15));
        7:       op = 8'hA0 | 8'($urandom_range(0, 1));
        8:       op = 8'hA2 | 8'($urandom_range(0, 1));
        default: op = 8'($urandom_range(0, 255));
      endcase
      add_byte(op);
      if (kind < 9) begin
        f = op_form(op);
        if (f <= FORM_IMM_TO_RM) add_byte(m);
        repeat (disp_count(f, m) + imm_count(f, op)) add_byte(8'($urandom_range(0, 255)));
      end
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    burst_left = 20;
    for (int i = 0; i < stim_q.size(); i++) begin
      in_valid <= 1'b1;
      in_code_byte <= stim_q[i].code;
      do @(posedge clk); while (in_stall);
      if (decode_byte(stim_q[i].code, pred))
        exp_q.push_back(stim_q[i].typed ? stim_q[i].want : pred);
      sent_cnt++;
      burst_left--;
      // At the three drain points, hold off new requests until all outstanding records drain.
      if (i + 1 == n_directed || i + 1 == drain_at || i + 1 == stim_q.size()) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (exp_q.size() != 0);
      end else if (burst_left <= 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 150)
                                                 : $urandom_range(1, 12);
      end
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Drove %0d code bytes (%0d from the directed table), checked %0d records, %0d errors",
             sent_cnt, n_directed, rec_cnt, err_cnt);
    $display("Records by form: rm-reg %0d, imm-to-rm %0d, imm-to-reg %0d, %s %0d, %s %0d, %s %0d",
             form_seen[0], form_seen[1], form_seen[2], "mem-to-acc", form_seen[3],
             "acc-to-mem", form_seen[4], "not-mov", form_seen[5]);
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
